FILE: rtl/brmq_pkg.sv
package brmq_pkg;

    localparam int unsigned IDX_W      = 10;
    localparam int unsigned VAL_W      = 32;
    localparam int unsigned REM_W      = 8;
    localparam int unsigned CNT_W      = 11;
    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned CFG_DATA_W = 32;

    localparam logic [CNT_W-1:0] COUNT_RESET = 11'd1024;

    localparam logic REG_ELEMENT_COUNT = 1'b0;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_BAD = 1'b1;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_QUERY = 1'b1
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ISSUE,
        S_ISSUE_E,
        S_SPLIT,
        S_W_READ,
        S_W_UPD,
        S_CHECK,
        S_SCAN_A,
        S_SCAN_B,
        S_SCAN_C,
        S_DRAIN,
        S_OUT
    } t_state;

    typedef enum logic {
        TAG_LOW  = 1'b0,
        TAG_HIGH = 1'b1
    } t_split_tag;

    typedef struct packed {
        logic             valid;
        t_split_tag       tag;
        logic [IDX_W-1:0] index;
    } t_split_req;

    typedef struct packed {
        logic             valid;
        t_split_tag       tag;
        logic [IDX_W-1:0] quot;
        logic [REM_W-1:0] rem;
    } t_split_rsp;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic [IDX_W-1:0]        position;
    } t_summary;

endpackage

FILE: rtl/brmq_if.sv
interface brmq_req_if import brmq_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic                    operation;
    logic [IDX_W-1:0]        write_index;
    logic signed [VAL_W-1:0] write_value;
    logic [IDX_W-1:0]        range_start;
    logic [IDX_W-1:0]        range_end;

    modport source (
        output valid, operation, write_index, write_value, range_start, range_end,
        input  ready
    );
    modport sink (
        input  valid, operation, write_index, write_value, range_start, range_end,
        output ready
    );
endinterface

interface brmq_rsp_if import brmq_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [VAL_W-1:0] min_value;
    logic [IDX_W-1:0]        min_position;
    logic                    status;

    modport source (
        output valid, min_value, min_position, status,
        input  ready
    );
    modport sink (
        input  valid, min_value, min_position, status,
        output ready
    );
endinterface

FILE: rtl/brmq_ram.sv
module brmq_ram import brmq_pkg::*; #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 1024,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/brmq_div.sv
module brmq_div import brmq_pkg::*; #(
    parameter int unsigned BLOCK_LENGTH = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_split_req i_req,
    output t_split_rsp o_rsp
);

    localparam int unsigned K  = 16;
    localparam int unsigned M  = (1 << K) / BLOCK_LENGTH;
    localparam int unsigned PW = IDX_W + K + 1;
    localparam int unsigned RW = 2 * IDX_W;

    logic             r_vld1;
    t_split_tag       r_tag1;
    logic [IDX_W-1:0] r_num;
    logic [PW-1:0]    r_prod;

    logic [IDX_W-1:0] q0;
    logic [RW-1:0]    r0;
    logic             over;

    t_split_rsp r_rsp;

    always_comb begin
        q0   = IDX_W'(r_prod >> K);
        r0   = RW'(r_num) - RW'(q0) * RW'(BLOCK_LENGTH);
        over = (r0 >= RW'(BLOCK_LENGTH));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1      <= 1'b0;
            r_rsp.valid <= 1'b0;
        end else begin
            r_vld1      <= i_req.valid;
            r_rsp.valid <= r_vld1;
        end
        r_tag1 <= i_req.tag;
        r_num  <= i_req.index;
        r_prod <= PW'(i_req.index) * PW'(M);
        r_rsp.tag <= r_tag1;
        if (over) begin
            r_rsp.quot <= q0 + IDX_W'(1);
            r_rsp.rem  <= REM_W'(r0 - RW'(BLOCK_LENGTH));
        end else begin
            r_rsp.quot <= q0;
            r_rsp.rem  <= REM_W'(r0);
        end
    end

    assign o_rsp = r_rsp;

endmodule

FILE: rtl/block_range_min_query.sv
// Range-minimum engine over a stored array of signed 32-bit elements.
// Requests arrive on i_req: operation 0 writes write_value at write_index,
// operation 1 asks for the minimum over range_start..range_end inclusive.
// A write gives no result; a query gives one transfer on o_rsp with the
// minimum, its leftmost position and a status (1 = bad range, value and
// position then zero). element_count sits at APB address 0, reset 1024.
// Load elements in ascending index order so the per-block summaries hold.
// Items are taken one at a time. A write splits the index by the block
// length, then does a read-modify-write of the block summary. A query
// reads the elements of the two partial end blocks and the summary of
// each whole block between them one by one, since every element and
// summary comes through a single read port of its memory.
// The result sits in an output register, so a new request is taken while
// it waits; a finished query holds until that register is free.
// Reset clears the control state and sets element_count to 1024; the memories are
// left as they are and hold nothing meaningful until written.
module block_range_min_query import brmq_pkg::*; #(
    parameter int unsigned ARRAY_DEPTH  = 1024,
    parameter int unsigned BLOCK_LENGTH = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    brmq_req_if.sink              i_req,
    brmq_rsp_if.source            o_rsp,
    input  logic                  i_psel,
    input  logic                  i_penable,
    input  logic                  i_pwrite,
    input  logic [CFG_ADDR_W-1:0] i_paddr,
    input  logic [CFG_DATA_W-1:0] i_pwdata,
    output logic [CFG_DATA_W-1:0] o_prdata,
    output logic                  o_pready
);

    localparam int unsigned BLOCK_TOTAL = (ARRAY_DEPTH + BLOCK_LENGTH - 1) / BLOCK_LENGTH;
    localparam int unsigned EAW = (ARRAY_DEPTH > 1) ? $clog2(ARRAY_DEPTH) : 1;
    localparam int unsigned BAW = (BLOCK_TOTAL > 1) ? $clog2(BLOCK_TOTAL) : 1;

    t_state r_state, n_state;

    logic [CNT_W-1:0] r_count;

    t_op                     r_op;
    logic [IDX_W-1:0]        r_widx;
    logic signed [VAL_W-1:0] r_wval;
    logic [IDX_W-1:0]        r_s;
    logic [IDX_W-1:0]        r_e;
    logic [IDX_W-1:0]        r_sb, r_eb;
    logic [REM_W-1:0]        r_soff, r_eoff;

    logic [IDX_W-1:0]        r_addr, r_hi, r_blk;
    logic                    r_rd_vld, r_rd_blk;
    logic [IDX_W-1:0]        r_rd_pos;
    logic                    r_have;
    logic signed [VAL_W-1:0] r_best;
    logic [IDX_W-1:0]        r_pos;
    logic                    r_status;

    logic                    r_out_valid;
    logic signed [VAL_W-1:0] r_out_value;
    logic [IDX_W-1:0]        r_out_pos;
    logic                    r_out_status;

    t_split_req split_req;
    t_split_rsp split_rsp;

    logic             elem_we, elem_re;
    logic [VAL_W-1:0] elem_rdata;
    logic             blk_we, blk_re;
    logic [BAW-1:0]   blk_raddr;
    t_summary         blk_wdata, blk_rdata;

    logic                    req_ready, scan_issue, out_load;
    logic                    w_in_depth, q_bad, cfg_we;
    logic signed [VAL_W-1:0] cand_value;
    logic [IDX_W-1:0]        cand_pos;

    assign w_in_depth = (32'(r_widx) < ARRAY_DEPTH);
    assign q_bad      = (r_s > r_e) || ({1'b0, r_e} >= r_count) || (32'(r_e) >= ARRAY_DEPTH);
    assign cand_value = r_rd_blk ? blk_rdata.value : $signed(elem_rdata);
    assign cand_pos   = r_rd_blk ? blk_rdata.position : r_rd_pos;
    assign blk_wdata  = '{value: r_wval, position: r_widx};

    brmq_div #(
        .BLOCK_LENGTH(BLOCK_LENGTH)
    ) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (split_req),
        .o_rsp  (split_rsp)
    );

    brmq_ram #(
        .WIDTH(VAL_W),
        .DEPTH(ARRAY_DEPTH)
    ) u_elem_ram (
        .i_clk  (i_clk),
        .i_we   (elem_we),
        .i_waddr(EAW'(r_widx)),
        .i_wdata(r_wval),
        .i_re   (elem_re),
        .i_raddr(EAW'(r_addr)),
        .o_rdata(elem_rdata)
    );

    brmq_ram #(
        .WIDTH($bits(t_summary)),
        .DEPTH(BLOCK_TOTAL)
    ) u_blk_ram (
        .i_clk  (i_clk),
        .i_we   (blk_we),
        .i_waddr(BAW'(r_sb)),
        .i_wdata(blk_wdata),
        .i_re   (blk_re),
        .i_raddr(blk_raddr),
        .o_rdata(blk_rdata)
    );

    always_comb begin
        n_state         = r_state;
        req_ready       = 1'b0;
        split_req.valid = 1'b0;
        split_req.tag   = TAG_LOW;
        split_req.index = (r_op == OP_QUERY) ? r_s : r_widx;
        elem_we         = 1'b0;
        elem_re         = 1'b0;
        blk_we          = 1'b0;
        blk_re          = 1'b0;
        blk_raddr       = BAW'(r_sb);
        scan_issue      = 1'b0;
        out_load        = 1'b0;
        case (r_state)
            S_IDLE: begin
                req_ready = 1'b1;
                if (i_req.valid) begin
                    n_state = S_ISSUE;
                end
            end
            S_ISSUE: begin
                if (r_op == OP_QUERY) begin
                    split_req.valid = 1'b1;
                    n_state         = S_ISSUE_E;
                end else if (w_in_depth) begin
                    split_req.valid = 1'b1;
                    elem_we         = 1'b1;
                    n_state         = S_SPLIT;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_ISSUE_E: begin
                split_req.valid = 1'b1;
                split_req.tag   = TAG_HIGH;
                split_req.index = r_e;
                n_state         = S_SPLIT;
            end
            S_SPLIT: begin
                if (split_rsp.valid) begin
                    if (r_op == OP_WRITE && split_rsp.tag == TAG_LOW) begin
                        n_state = S_W_READ;
                    end else if (r_op == OP_QUERY && split_rsp.tag == TAG_HIGH) begin
                        n_state = S_CHECK;
                    end
                end
            end
            S_W_READ: begin
                blk_re  = 1'b1;
                n_state = S_W_UPD;
            end
            S_W_UPD: begin
                blk_we  = (r_soff == '0) || (r_wval < blk_rdata.value);
                n_state = S_IDLE;
            end
            S_CHECK: begin
                n_state = q_bad ? S_OUT : S_SCAN_A;
            end
            S_SCAN_A: begin
                elem_re    = 1'b1;
                scan_issue = 1'b1;
                if (r_addr == r_hi) begin
                    if (r_sb == r_eb) begin
                        n_state = S_DRAIN;
                    end else if (r_eb > r_sb + IDX_W'(1)) begin
                        n_state = S_SCAN_B;
                    end else begin
                        n_state = S_SCAN_C;
                    end
                end
            end
            S_SCAN_B: begin
                blk_re     = 1'b1;
                blk_raddr  = BAW'(r_blk);
                scan_issue = 1'b1;
                if (r_blk == r_eb - IDX_W'(1)) begin
                    n_state = S_SCAN_C;
                end
            end
            S_SCAN_C: begin
                elem_re    = 1'b1;
                scan_issue = 1'b1;
                if (r_addr == r_e) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || o_rsp.ready) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= COUNT_RESET;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= scan_issue;
            if (cfg_we && i_paddr[CFG_ADDR_W-1] == REG_ELEMENT_COUNT) begin
                r_count <= i_pwdata[CNT_W-1:0];
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && req_ready) begin
            r_op   <= t_op'(i_req.operation);
            r_widx <= i_req.write_index;
            r_wval <= i_req.write_value;
            r_s    <= i_req.range_start;
            r_e    <= i_req.range_end;
        end
        if (split_rsp.valid) begin
            if (split_rsp.tag == TAG_LOW) begin
                r_sb   <= split_rsp.quot;
                r_soff <= split_rsp.rem;
            end else begin
                r_eb   <= split_rsp.quot;
                r_eoff <= split_rsp.rem;
            end
        end
        case (r_state)
            S_CHECK: begin
                r_addr   <= r_s;
                r_hi     <= (r_sb == r_eb) ? r_e
                          : r_s - IDX_W'(r_soff) + IDX_W'(BLOCK_LENGTH - 1);
                r_have   <= 1'b0;
                r_status <= q_bad ? STATUS_BAD : STATUS_OK;
                if (q_bad) begin
                    r_best <= '0;
                    r_pos  <= '0;
                end
            end
            S_SCAN_A: begin
                if (r_addr == r_hi) begin
                    r_blk  <= r_sb + IDX_W'(1);
                    r_addr <= r_e - IDX_W'(r_eoff);
                end else begin
                    r_addr <= r_addr + IDX_W'(1);
                end
            end
            S_SCAN_B: begin
                r_blk <= r_blk + IDX_W'(1);
            end
            S_SCAN_C: begin
                r_addr <= r_addr + IDX_W'(1);
            end
            default: begin
            end
        endcase
        r_rd_pos <= r_addr;
        r_rd_blk <= (r_state == S_SCAN_B);
        if (r_rd_vld && (!r_have || cand_value < r_best)) begin
            r_have <= 1'b1;
            r_best <= cand_value;
            r_pos  <= cand_pos;
        end
        if (out_load) begin
            r_out_value  <= r_best;
            r_out_pos    <= r_pos;
            r_out_status <= r_status;
        end
    end

    assign i_req.ready        = req_ready;
    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.min_value    = r_out_value;
    assign o_rsp.min_position = r_out_pos;
    assign o_rsp.status       = r_out_status;

    assign cfg_we   = i_psel && i_penable && i_pwrite;
    assign o_pready = 1'b1;
    assign o_prdata = (i_paddr[CFG_ADDR_W-1] == REG_ELEMENT_COUNT)
                    ? CFG_DATA_W'(r_count) : '0;

    a_split_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        split_req.valid |-> ##2 split_rsp.valid)
        else $error("split response missing two cycles after request");

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.status == STATUS_BAD)
            |-> (o_rsp.min_value == '0 && o_rsp.min_position == '0))
        else $error("bad range result carries non-zero fields");

    a_drain_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DRAIN |-> r_rd_vld)
        else $error("drain without a read in flight");

    a_check_after_split: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CHECK |-> $past(split_rsp.valid && split_rsp.tag == TAG_HIGH))
        else $error("range check before end index split");

    a_no_elem_write_in_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        elem_we |-> (r_op == OP_WRITE && r_state == S_ISSUE))
        else $error("element store written outside a write transfer");

endmodule

FILE: dv/tb_block_range_min_query.sv
module tb_block_range_min_query;
    timeunit 1ns;
    timeprecision 1ps;
    import brmq_pkg::*;

    localparam int ARRAY_DEPTH   = 1024;
    localparam int BLOCK_LENGTH  = 16;
    localparam int BLOCK_TOTAL   = ARRAY_DEPTH / BLOCK_LENGTH;
    localparam int ITEM_TARGET   = 1250;
    localparam int SETTLE_CYCLES = 40;
    localparam int STALL_LIMIT   = 2000;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic [IDX_W-1:0]        position;
        logic                    status;
    } t_range_min;

    typedef enum logic [1:0] {
        ROW_WRITE,
        ROW_QUERY,
        ROW_COUNT
    } t_row_kind;

    typedef enum logic [1:0] {
        MIX_WIDE,
        MIX_NARROW,
        MIX_EDGES
    } t_value_mix;

    typedef struct packed {
        t_row_kind               kind;
        logic [IDX_W-1:0]        first;
        logic [IDX_W-1:0]        last;
        logic signed [VAL_W-1:0] value;
        logic                    typed;
        t_range_min              outcome;
    } t_stim_row;

    localparam t_range_min NO_OUTCOME = '{32'sd0, 10'd0, STATUS_OK};
    localparam t_range_min BAD_RANGE  = '{32'sd0, 10'd0, STATUS_BAD};

    localparam t_stim_row DIRECTED_ROWS [24] = '{
        '{ROW_QUERY, 10'd7,    10'd3,  32'sd0,           1'b1, BAD_RANGE},
        '{ROW_QUERY, 10'd1023, 10'd0,  32'sd0,           1'b1, BAD_RANGE},
        '{ROW_WRITE, 10'd0,    10'd0,  32'sh7FFFFFFF,    1'b0, NO_OUTCOME},
        '{ROW_QUERY, 10'd0,    10'd0,  32'sd0,           1'b1,
            '{32'sh7FFFFFFF, 10'd0, STATUS_OK}},
        '{ROW_WRITE, 10'd1,    10'd0,  32'sh80000000,    1'b0, NO_OUTCOME},
        '{ROW_WRITE, 10'd2,    10'd0,  32'sh80000000,    1'b0, NO_OUTCOME},
        '{ROW_QUERY, 10'd0,    10'd2,  32'sd0,           1'b1,
            '{32'sh80000000, 10'd1, STATUS_OK}},
        '{ROW_QUERY, 10'd2,    10'd2,  32'sd0,           1'b1,
            '{32'sh80000000, 10'd2, STATUS_OK}},
        '{ROW_WRITE, 10'd16,   10'd0,  32'sd0,           1'b0, NO_OUTCOME},
        '{ROW_WRITE, 10'd17,   10'd0,  -32'sd1,          1'b0, NO_OUTCOME},
        '{ROW_WRITE, 10'd18,   10'd0,  -32'sd1,          1'b0, NO_OUTCOME},
        '{ROW_QUERY, 10'd16,   10'd18, 32'sd0,           1'b0, NO_OUTCOME},
        '{ROW_WRITE, 10'd32,   10'd0,  32'sd5,           1'b0, NO_OUTCOME},
        '{ROW_WRITE, 10'd48,   10'd0,  32'sd9,           1'b0, NO_OUTCOME},
        '{ROW_WRITE, 10'd15,   10'd0,  -32'sd7,          1'b0, NO_OUTCOME},
        '{ROW_QUERY, 10'd15,   10'd48, 32'sd0,           1'b0, NO_OUTCOME},
        '{ROW_WRITE, 10'd15,   10'd0,  32'sd100,         1'b0, NO_OUTCOME},
        '{ROW_WRITE, 10'd16,   10'd0,  32'sd3,           1'b0, NO_OUTCOME},
        '{ROW_QUERY, 10'd15,   10'd48, 32'sd0,           1'b0, NO_OUTCOME},
        '{ROW_COUNT, 10'd0,    10'd0,  32'sd1,           1'b0, NO_OUTCOME},
        '{ROW_QUERY, 10'd0,    10'd1,  32'sd0,           1'b1, BAD_RANGE},
        '{ROW_QUERY, 10'd0,    10'd0,  32'sd0,           1'b1,
            '{32'sh7FFFFFFF, 10'd0, STATUS_OK}},
        '{ROW_COUNT, 10'd0,    10'd0,  32'sd1024,        1'b0, NO_OUTCOME},
        '{ROW_QUERY, 10'd0,    10'd1,  32'sd0,           1'b1,
            '{32'sh80000000, 10'd1, STATUS_OK}}
    };

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_psel;
    logic                  i_penable;
    logic                  i_pwrite;
    logic [CFG_ADDR_W-1:0] i_paddr;
    logic [CFG_DATA_W-1:0] i_pwdata;
    logic [CFG_DATA_W-1:0] o_prdata;
    logic                  o_pready;

    brmq_req_if req_bus ();
    brmq_rsp_if rsp_bus ();

    logic signed [VAL_W-1:0] shadow_elements  [ARRAY_DEPTH];
    logic signed [VAL_W-1:0] shadow_block_min [BLOCK_TOTAL];
    logic [IDX_W-1:0]        shadow_block_pos [BLOCK_TOTAL];
    logic [CNT_W-1:0]        shadow_count;
    bit                      elem_loaded      [ARRAY_DEPTH];
    bit                      block_loaded     [BLOCK_TOTAL];
    t_range_min              range_min_due    [$];

    int errors       = 0;
    int items_sent   = 0;
    int quiet_cycles = 0;
    bit sender_steady   = 1'b0;
    bit receiver_steady = 1'b0;

    block_range_min_query dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (req_bus),
        .o_rsp     (rsp_bus),
        .i_psel    (i_psel),
        .i_penable (i_penable),
        .i_pwrite  (i_pwrite),
        .i_paddr   (i_paddr),
        .i_pwdata  (i_pwdata),
        .o_prdata  (o_prdata),
        .o_pready  (o_pready)
    );

    always #2 i_clk = ~i_clk;

    function automatic void absorb_write(int idx, logic signed [VAL_W-1:0] v);
        int blk;
        blk = idx / BLOCK_LENGTH;
        shadow_elements[idx] = v;
        elem_loaded[idx] = 1'b1;
        if (idx % BLOCK_LENGTH == 0 || v < shadow_block_min[blk]) begin
            shadow_block_min[blk] = v;
            shadow_block_pos[blk] = IDX_W'(idx);
            block_loaded[blk] = 1'b1;
        end
    endfunction

    function automatic bit range_is_readable(int s, int e);
        int sb;
        int eb;
        int top;
        if (s > e || e >= int'(shadow_count)) return 1'b1;
        sb = s / BLOCK_LENGTH;
        eb = e / BLOCK_LENGTH;
        top = (sb == eb) ? e : (sb + 1) * BLOCK_LENGTH - 1;
        for (int i = s; i <= top; i++)
            if (!elem_loaded[i]) return 1'b0;
        if (sb != eb) begin
            for (int b = sb + 1; b < eb; b++)
                if (!block_loaded[b]) return 1'b0;
            for (int i = eb * BLOCK_LENGTH; i <= e; i++)
                if (!elem_loaded[i]) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic t_range_min predict_range_min(int s, int e);
        logic signed [VAL_W-1:0] lowest;
        int spot;
        int sb;
        int eb;
        int top;
        if (s > e || e >= int'(shadow_count)) return BAD_RANGE;
        sb = s / BLOCK_LENGTH;
        eb = e / BLOCK_LENGTH;
        top = (sb == eb) ? e : (sb + 1) * BLOCK_LENGTH - 1;
        lowest = shadow_elements[s];
        spot = s;
        for (int i = s + 1; i <= top; i++) begin
            if (shadow_elements[i] < lowest) begin
                lowest = shadow_elements[i];
                spot = i;
            end
        end
        if (sb != eb) begin
            for (int b = sb + 1; b < eb; b++) begin
                if (shadow_block_min[b] < lowest) begin
                    lowest = shadow_block_min[b];
                    spot = int'(shadow_block_pos[b]);
                end
            end
            for (int i = eb * BLOCK_LENGTH; i <= e; i++) begin
                if (shadow_elements[i] < lowest) begin
                    lowest = shadow_elements[i];
                    spot = i;
                end
            end
        end
        return '{lowest, IDX_W'(spot), STATUS_OK};
    endfunction

    function automatic logic signed [VAL_W-1:0] draw_value(t_value_mix mix);
        case (mix)
            MIX_WIDE:   return $urandom;
            MIX_NARROW: return $signed($urandom_range(0, 6)) - 3;
            default: begin
                case ($urandom_range(0, 4))
                    0:       return 32'sh80000000;
                    1:       return 32'sh7FFFFFFF;
                    2:       return 32'sd0;
                    3:       return -32'sd1;
                    default: return $urandom;
                endcase
            end
        endcase
    endfunction

    task automatic transfer_request(t_op op, logic [IDX_W-1:0] idx,
                                    logic signed [VAL_W-1:0] val,
                                    logic [IDX_W-1:0] s, logic [IDX_W-1:0] e);
        int gap;
        gap = sender_steady ? 0 : int'($urandom_range(0, 5));
        if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_bus.valid       <= 1'b1;
        req_bus.operation   <= op;
        req_bus.write_index <= idx;
        req_bus.write_value <= val;
        req_bus.range_start <= s;
        req_bus.range_end   <= e;
        do @(posedge i_clk); while (req_bus.ready !== 1'b1);
        items_sent++;
    endtask

    task automatic issue_write(int idx, logic signed [VAL_W-1:0] v);
        transfer_request(OP_WRITE, IDX_W'(idx), v, IDX_W'($urandom), IDX_W'($urandom));
        absorb_write(idx, v);
    endtask

    task automatic issue_query(int s, int e, bit typed, t_range_min outcome);
        transfer_request(OP_QUERY, IDX_W'($urandom), $urandom, IDX_W'(s), IDX_W'(e));
        range_min_due.push_back(typed ? outcome : predict_range_min(s, e));
    endtask

    task automatic stray_write(t_value_mix mix);
        int idx;
        idx = $urandom_range(0, ARRAY_DEPTH - 1);
        if (!block_loaded[idx / BLOCK_LENGTH]) idx -= idx % BLOCK_LENGTH;
        issue_write(idx, draw_value(mix));
    endtask

    task automatic settle();
        req_bus.valid <= 1'b0;
        while (range_min_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic count_reg_access(logic wr, logic [CFG_DATA_W-1:0] wdata,
                                    output logic [CFG_DATA_W-1:0] rdata);
        i_psel    <= 1'b1;
        i_penable <= 1'b0;
        i_pwrite  <= wr;
        i_paddr   <= {REG_ELEMENT_COUNT, 2'b00};
        i_pwdata  <= wdata;
        @(posedge i_clk);
        i_penable <= 1'b1;
        do @(posedge i_clk); while (o_pready !== 1'b1);
        rdata = o_prdata;
        i_psel    <= 1'b0;
        i_penable <= 1'b0;
    endtask

    task automatic check_count_reg(logic [CNT_W-1:0] want);
        logic [CFG_DATA_W-1:0] got;
        count_reg_access(1'b0, '0, got);
        if (got !== CFG_DATA_W'(want)) begin
            errors++;
            $display("%0t: element_count read expected %0d got %0d", $time, want, got);
        end
    endtask

    task automatic set_element_count(logic [CNT_W-1:0] count);
        logic [CFG_DATA_W-1:0] ignored;
        settle();
        count_reg_access(1'b1, CFG_DATA_W'(count), ignored);
        shadow_count = count;
        @(posedge i_clk);
        check_count_reg(count);
    endtask

    initial begin : result_sink
        t_range_min want;
        int stall;
        rsp_bus.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            stall = receiver_steady ? 0 : int'($urandom_range(0, 5));
            if (stall > 0) begin
                rsp_bus.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            rsp_bus.ready <= 1'b1;
            do @(posedge i_clk); while (rsp_bus.valid !== 1'b1);
            if (range_min_due.size() == 0) begin
                errors++;
                $display("%0t: unexpected transfer: expected none got value %0d position %0d status %0d",
                         $time, $signed(rsp_bus.min_value), rsp_bus.min_position,
                         rsp_bus.status);
            end else begin
                want = range_min_due.pop_front();
                if (rsp_bus.min_value !== want.value) begin
                    errors++;
                    $display("%0t: min_value expected %0d got %0d", $time,
                             $signed(want.value), $signed(rsp_bus.min_value));
                end
                if (rsp_bus.min_position !== want.position) begin
                    errors++;
                    $display("%0t: min_position expected %0d got %0d", $time,
                             want.position, rsp_bus.min_position);
                end
                if (rsp_bus.status !== want.status) begin
                    errors++;
                    $display("%0t: status expected %0d got %0d", $time,
                             want.status, rsp_bus.status);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
            (i_psel && i_penable)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        t_stim_row        row;
        t_value_mix       mix;
        logic [CNT_W-1:0] count;
        int phase;
        int base;
        int span;
        int queries;
        int pick;
        int s;
        int e;

        i_rst_n             <= 1'b0;
        req_bus.valid       <= 1'b0;
        req_bus.operation   <= OP_WRITE;
        req_bus.write_index <= '0;
        req_bus.write_value <= '0;
        req_bus.range_start <= '0;
        req_bus.range_end   <= '0;
        i_psel              <= 1'b0;
        i_penable           <= 1'b0;
        i_pwrite            <= 1'b0;
        i_paddr             <= '0;
        i_pwdata            <= '0;
        shadow_count = COUNT_RESET;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        check_count_reg(COUNT_RESET);

        for (int r = 0; r < $size(DIRECTED_ROWS); r++) begin
            row = DIRECTED_ROWS[r];
            case (row.kind)
                ROW_WRITE: issue_write(int'(row.first), row.value);
                ROW_QUERY: issue_query(int'(row.first), int'(row.last), row.typed, row.outcome);
                default:   set_element_count(CNT_W'(row.value));
            endcase
        end

        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            base = $urandom_range(0, BLOCK_TOTAL - 1) * BLOCK_LENGTH;
            span = ($urandom_range(0, 7) == 0) ? int'($urandom_range(49, 160))
                                                : int'($urandom_range(1, 48));
            if (base + span > ARRAY_DEPTH) span = ARRAY_DEPTH - base;
            pick = $urandom_range(0, 9);
            if (phase == 0 || pick == 0)
                count = CNT_W'(ARRAY_DEPTH);
            else if (phase == 1 || pick == 1)
                count = CNT_W'(1);
            else
                count = CNT_W'($urandom_range(base + span, ARRAY_DEPTH));
            set_element_count(count);
            sender_steady   = ($urandom_range(0, 3) == 0);
            receiver_steady = ($urandom_range(0, 3) == 0);
            mix = t_value_mix'($urandom_range(0, 2));

            for (int k = 0; k < span; k++) begin
                if ($urandom_range(0, 19) == 0) stray_write(mix);
                issue_write(base + k, draw_value(mix));
            end

            queries = $urandom_range(6, 16);
            for (int q = 0; q < queries; q++) begin
                if ($urandom_range(0, 9) == 0) stray_write(mix);
                pick = $urandom_range(0, 9);
                if (pick < 7) begin
                    s = base + $urandom_range(0, span - 1);
                    e = base + $urandom_range(0, span - 1);
                    if (s > e) {s, e} = {e, s};
                end else if (pick < 8) begin
                    s = base + $urandom_range(0, span - 1);
                    e = s;
                end else begin
                    s = $urandom_range(0, ARRAY_DEPTH - 1);
                    e = $urandom_range(0, ARRAY_DEPTH - 1);
                end
                // turn a range over unloaded entries into an inverted one
                if (!range_is_readable(s, e)) begin
                    if (s == e) begin
                        if (s == 0) s = 1;
                        else e = s - 1;
                    end else if (s < e) begin
                        {s, e} = {e, s};
                    end
                end
                issue_query(s, e, 1'b0, NO_OUTCOME);
            end
            phase++;
        end

        settle();
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
